[rtl/core/reservation_station_wakeup_select_defines.svh]
// Assertion macros shared by the reservation station RTL.
// Depends on nothing; define ASSERT_OFF to compile the checks out.
`ifndef RESERVATION_STATION_WAKEUP_SELECT_DEFINES_SVH
`define RESERVATION_STATION_WAKEUP_SELECT_DEFINES_SVH
`ifndef ASSERT_OFF
`define RSWS_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("reservation station check failed");
`define RSWS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("reservation station check failed");
`else
`define RSWS_ASSERT_SAME(label, clk, rst, ante, cons)
`define RSWS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

[rtl/core/rsws_pkg.sv]
// Types, constants and the readiness decode of the reservation station.
// Used by rsws_cell and reservation_station_wakeup_select.
`default_nettype none

package rsws_pkg;

   localparam int unsigned TAG_W  = 5;
   localparam int unsigned OP_W   = 5;
   localparam int unsigned DATA_W = 32;
   localparam int unsigned FLAG_W = 6;

   // Bits of the control field.
   localparam int unsigned CTL_FLUSH = 0;
   localparam int unsigned CTL_ISSUE = 1;
   localparam int unsigned CTL_ALU   = 2;
   localparam int unsigned CTL_LSQ   = 3;

   // Bits of the operand flags.
   localparam int unsigned FL_PC  = 0;
   localparam int unsigned FL_OFF = 1;
   localparam int unsigned FL_V1  = 2;
   localparam int unsigned FL_V2  = 3;
   localparam int unsigned FL_W1  = 4;
   localparam int unsigned FL_W2  = 5;

   // Op class boundaries.
   localparam logic [OP_W-1:0] OP_LAST_ALU    = 5'd18;
   localparam logic [OP_W-1:0] OP_LAST_BRANCH = 5'd24;
   localparam logic [OP_W-1:0] OP_JAL         = 5'd25;
   localparam logic [OP_W-1:0] OP_JALR        = 5'd26;
   localparam logic [OP_W-1:0] OP_AUIPC       = 5'd27;
   localparam logic [OP_W-1:0] OP_LUI         = 5'd28;

   typedef struct packed {
      logic [3:0]        control;
      logic [OP_W-1:0]   issue_op;
      logic [TAG_W-1:0]  issue_tag;
      logic [DATA_W-1:0] issue_pc;
      logic [DATA_W-1:0] issue_offset;
      logic [FLAG_W-1:0] issue_flags;
      logic [DATA_W-1:0] issue_src1;
      logic [DATA_W-1:0] issue_src2;
      logic [TAG_W-1:0]  alu_bcast_tag;
      logic [DATA_W-1:0] alu_bcast_value;
      logic [TAG_W-1:0]  lsq_bcast_tag;
      logic [DATA_W-1:0] lsq_bcast_value;
   } req_type;

   typedef struct packed {
      logic              has_free_slot;
      logic              dispatch_valid;
      logic [OP_W-1:0]   out_op;
      logic [TAG_W-1:0]  out_tag;
      logic [DATA_W-1:0] out_pc;
      logic [DATA_W-1:0] out_offset;
      logic [DATA_W-1:0] out_src1;
      logic [DATA_W-1:0] out_src2;
      logic              issue_dropped;
   } rsp_type;

   // Contents of one station entry. While an operand waits, its producer
   // tag sits in the low bits of the operand word.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] pc;
      logic [DATA_W-1:0] offset;
      logic [FLAG_W-1:0] flags;
      logic [DATA_W-1:0] first;
      logic [DATA_W-1:0] second;
   } entry_type;

   typedef struct packed {
      logic              any;
      logic              pc;
      logic              off;
      logic              s1;
      logic              s2;
   } sends_type;

   // Dispatch payload carried down the row of cells.
   typedef struct packed {
      logic [OP_W-1:0]   op;
      logic [TAG_W-1:0]  tag;
      logic [DATA_W-1:0] pc;
      logic [DATA_W-1:0] offset;
      logic [DATA_W-1:0] src1;
      logic [DATA_W-1:0] src2;
   } dsp_type;

   // What a cell hands to its higher-numbered neighbor.
   typedef struct packed {
      logic    ready_seen;
      logic    free_seen;
      logic    free_before_seen;
      dsp_type dsp;
   } link_type;

   typedef struct packed {
      logic commit;
      logic select_en;
   } ctl_type;

   function automatic sends_type ready_sends(logic [OP_W-1:0] op, logic [FLAG_W-1:0] f);
      sends_type s;
      logic      pc;
      logic      off;
      logic      v1;
      logic      v2;
      pc  = f[FL_PC];
      off = f[FL_OFF];
      v1  = f[FL_V1];
      v2  = f[FL_V2];
      s   = '0;
      if (op <= OP_LAST_ALU) begin
         s.any = v1 & v2;
         s.s1  = 1'b1;
         s.s2  = 1'b1;
      end else if (op <= OP_LAST_BRANCH) begin
         s.any = v1 & v2 & pc & off;
         s.s1  = 1'b1;
         s.s2  = 1'b1;
         s.pc  = 1'b1;
         s.off = 1'b1;
      end else if (op == OP_JAL) begin
         s.any = pc & off;
         s.pc  = 1'b1;
         s.off = 1'b1;
      end else if (op == OP_JALR) begin
         s.any = pc & v1 & v2;
         s.pc  = 1'b1;
         s.s1  = 1'b1;
         s.s2  = 1'b1;
      end else if (op == OP_AUIPC) begin
         s.any = pc & v2;
         s.pc  = 1'b1;
         s.s2  = 1'b1;
      end else if (op == OP_LUI) begin
         s.any = v2;
         s.s2  = 1'b1;
      end
      return s;
   endfunction

endpackage

`default_nettype wire

[rtl/core/rsws_cell.sv]
// One reservation station entry: storage, readiness, wakeup and its link
// in the select and free-slot chains. Depends on rsws_pkg.
`default_nettype none

module rsws_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire rsws_pkg::ctl_type  ctl,
   input  wire rsws_pkg::req_type  req,
   input  wire rsws_pkg::link_type link_in,
   output rsws_pkg::link_type      link_out,
   output logic                    used
);

   logic                used_ff;
   logic                used_in;
   rsws_pkg::entry_type entry_ff;
   rsws_pkg::entry_type entry_in;
   rsws_pkg::entry_type base;
   rsws_pkg::sends_type sends;
   rsws_pkg::dsp_type   mine;
   logic                eligible;
   logic                pick;
   logic                free_now;
   logic                fill;
   logic                flush;
   logic                alu_v;
   logic                lsq_v;
   logic                m1_alu;
   logic                m1_lsq;
   logic                m2_alu;
   logic                m2_lsq;

   assign flush = req.control[rsws_pkg::CTL_FLUSH];
   assign alu_v = req.control[rsws_pkg::CTL_ALU];
   assign lsq_v = req.control[rsws_pkg::CTL_LSQ];
   assign used  = used_ff;

   always_comb begin
      sends    = rsws_pkg::ready_sends(entry_ff.op, entry_ff.flags);
      eligible = used_ff & sends.any & ctl.select_en;
      pick     = eligible & ~link_in.ready_seen;
      // The entry dispatched this transfer is free for the issue.
      free_now = ~used_ff | pick;
      fill     = req.control[rsws_pkg::CTL_ISSUE] & ~flush & free_now & ~link_in.free_seen;

      mine.op     = entry_ff.op;
      mine.tag    = entry_ff.tag;
      mine.pc     = sends.pc  ? entry_ff.pc     : '0;
      mine.offset = sends.off ? entry_ff.offset : '0;
      mine.src1   = sends.s1  ? entry_ff.first  : '0;
      mine.src2   = sends.s2  ? entry_ff.second : '0;

      link_out.ready_seen       = link_in.ready_seen | eligible;
      link_out.free_seen        = link_in.free_seen | free_now;
      link_out.free_before_seen = link_in.free_before_seen | ~used_ff;
      link_out.dsp              = pick ? mine : link_in.dsp;

      if (flush) begin
         used_in = 1'b0;
      end else if (fill) begin
         used_in = 1'b1;
      end else if (pick) begin
         used_in = 1'b0;
      end else begin
         used_in = used_ff;
      end

      if (fill) begin
         base.op     = req.issue_op;
         base.tag    = req.issue_tag;
         base.pc     = req.issue_pc;
         base.offset = req.issue_offset;
         base.flags  = req.issue_flags;
         base.first  = req.issue_src1;
         base.second = req.issue_src2;
      end else begin
         base = entry_ff;
      end

      // The ALU bus wakes first; the LSQ bus sees only what is still waiting.
      m1_alu = alu_v & base.flags[rsws_pkg::FL_W1] &
               (base.first[rsws_pkg::TAG_W-1:0] == req.alu_bcast_tag);
      m1_lsq = lsq_v & base.flags[rsws_pkg::FL_W1] &
               (base.first[rsws_pkg::TAG_W-1:0] == req.lsq_bcast_tag);
      m2_alu = alu_v & base.flags[rsws_pkg::FL_W2] &
               (base.second[rsws_pkg::TAG_W-1:0] == req.alu_bcast_tag);
      m2_lsq = lsq_v & base.flags[rsws_pkg::FL_W2] &
               (base.second[rsws_pkg::TAG_W-1:0] == req.lsq_bcast_tag);

      entry_in = base;
      if (m1_alu) begin
         entry_in.first = req.alu_bcast_value;
      end else if (m1_lsq) begin
         entry_in.first = req.lsq_bcast_value;
      end
      if (m1_alu | m1_lsq) begin
         entry_in.flags[rsws_pkg::FL_W1] = 1'b0;
         entry_in.flags[rsws_pkg::FL_V1] = 1'b1;
      end
      if (m2_alu) begin
         entry_in.second = req.alu_bcast_value;
      end else if (m2_lsq) begin
         entry_in.second = req.lsq_bcast_value;
      end
      if (m2_alu | m2_lsq) begin
         entry_in.flags[rsws_pkg::FL_W2] = 1'b0;
         entry_in.flags[rsws_pkg::FL_V2] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= 1'b0;
      end else if (ctl.commit) begin
         used_ff <= used_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         entry_ff <= entry_in;
      end
   end

endmodule

`default_nettype wire

[rtl/core/reservation_station_wakeup_select.sv]
// Top level of the reservation station: a row of entry cells plus the
// result register. Depends on rsws_pkg, rsws_cell and the defines header.
`default_nettype none
`include "reservation_station_wakeup_select_defines.svh"

// Reservation station of STATION_ENTRIES entries. Every request transfer is
// one bundle of core traffic (flush, issue, two result broadcasts) and yields
// exactly one response, registered and shown the cycle after the transfer.
// A new request is taken in every cycle in which the response register is
// empty or its response is being taken: one item per clock while responses
// are taken. The select and free-slot chains ripple combinationally through
// all STATION_ENTRIES cells and set the cycle length: the lowest ready entry
// is dispatched and the lowest slot free after that dispatch takes the
// issue. The transfer after a flush dispatches nothing.
module reservation_station_wakeup_select #(
   parameter int unsigned STATION_ENTRIES = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire rsws_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output rsws_pkg::rsp_type      rsp_payload
);

   rsws_pkg::link_type         link [0:STATION_ENTRIES];
   logic [STATION_ENTRIES-1:0] used_vec;
   rsws_pkg::ctl_type          ctl;
   rsws_pkg::rsp_type          rsp_in;
   rsws_pkg::rsp_type          rsp_payload_ff;
   logic                       rsp_valid_ff;
   logic                       flush_seen_ff;
   logic                       accept;
   logic                       flush;

   assign req_ready   = ~rsp_valid_ff | rsp_ready;
   assign accept      = req_valid & req_ready;
   assign flush       = req_payload.control[rsws_pkg::CTL_FLUSH];
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   assign ctl.commit    = accept;
   assign ctl.select_en = ~flush_seen_ff;
   assign link[0]       = '0;

   for (genvar i = 0; i < STATION_ENTRIES; i++) begin : g_cell
      rsws_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .req      (req_payload),
         .link_in  (link[i]),
         .link_out (link[i+1]),
         .used     (used_vec[i])
      );
   end

   always_comb begin
      rsp_in.has_free_slot  = link[STATION_ENTRIES].free_before_seen;
      rsp_in.dispatch_valid = link[STATION_ENTRIES].ready_seen;
      rsp_in.out_op         = link[STATION_ENTRIES].dsp.op;
      rsp_in.out_tag        = link[STATION_ENTRIES].dsp.tag;
      rsp_in.out_pc         = link[STATION_ENTRIES].dsp.pc;
      rsp_in.out_offset     = link[STATION_ENTRIES].dsp.offset;
      rsp_in.out_src1       = link[STATION_ENTRIES].dsp.src1;
      rsp_in.out_src2       = link[STATION_ENTRIES].dsp.src2;
      rsp_in.issue_dropped  = req_payload.control[rsws_pkg::CTL_ISSUE] & ~flush &
                              ~link[STATION_ENTRIES].free_seen;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         flush_seen_ff <= 1'b0;
      end else if (accept) begin
         rsp_valid_ff  <= 1'b1;
         flush_seen_ff <= flush;
      end else if (rsp_ready) begin
         rsp_valid_ff  <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   `RSWS_ASSERT_NEXT(a_no_dispatch_after_flush, clock, reset,
      accept && flush_seen_ff, rsp_valid && !rsp_payload.dispatch_valid)
   `RSWS_ASSERT_SAME(a_idle_fields_zero, clock, reset,
      rsp_valid && !rsp_payload.dispatch_valid,
      rsp_payload.out_op == '0 && rsp_payload.out_tag == '0 && rsp_payload.out_pc == '0 &&
      rsp_payload.out_offset == '0 && rsp_payload.out_src1 == '0 &&
      rsp_payload.out_src2 == '0)
   `RSWS_ASSERT_SAME(a_drop_only_when_full, clock, reset,
      rsp_valid && rsp_payload.issue_dropped,
      !rsp_payload.has_free_slot && !rsp_payload.dispatch_valid)
   `RSWS_ASSERT_NEXT(a_flush_empties, clock, reset, accept && flush, used_vec == '0)
   `RSWS_ASSERT_SAME(a_hold_blocks_input, clock, reset, rsp_valid && !rsp_ready, !req_ready)

endmodule

`default_nettype wire

[tb/rsws_dispatch_checker.sv]
// Transfer monitor and dispatch predictor for the reservation station.
// Depends on rsws_pkg; it is instantiated beside the station by
// tb_reservation_station_wakeup_select.
module rsws_dispatch_checker #(
   parameter int STATION_SIZE = 16
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic              req_ready,
   input  wire rsws_pkg::req_type req_payload,
   input  wire logic              rsp_valid,
   input  wire logic              rsp_ready,
   input  wire rsws_pkg::rsp_type rsp_payload,
   output int                     mismatches,
   output int                     outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REPORT_LIMIT = 10;

   // Operand masks, laid out like the low four bits of the entry flags.
   localparam logic [3:0] NEED_PC  = 4'(1 << rsws_pkg::FL_PC);
   localparam logic [3:0] NEED_OFF = 4'(1 << rsws_pkg::FL_OFF);
   localparam logic [3:0] NEED_A   = 4'(1 << rsws_pkg::FL_V1);
   localparam logic [3:0] NEED_B   = 4'(1 << rsws_pkg::FL_V2);

   typedef struct packed {
      logic [rsws_pkg::OP_W-1:0]   op;
      logic [rsws_pkg::TAG_W-1:0]  rob_id;
      logic [rsws_pkg::DATA_W-1:0] pc;
      logic [rsws_pkg::DATA_W-1:0] offset;
      logic [rsws_pkg::FLAG_W-1:0] flags;
      logic [rsws_pkg::DATA_W-1:0] first;
      logic [rsws_pkg::DATA_W-1:0] second;
   } slot_type;

   logic              occupied [STATION_SIZE];
   slot_type          slots    [STATION_SIZE];
   logic              flush_prev;
   rsws_pkg::rsp_type dispatch_q [$];

   // Each op class needs exactly the operands that it forwards; zero means
   // the op never becomes ready.
   function automatic logic [3:0] operands_needed(logic [rsws_pkg::OP_W-1:0] op);
      logic [3:0] m;
      m = '0;
      if (op <= rsws_pkg::OP_LAST_ALU)
         m = NEED_A | NEED_B;
      else if (op <= rsws_pkg::OP_LAST_BRANCH)
         m = NEED_PC | NEED_OFF | NEED_A | NEED_B;
      else if (op == rsws_pkg::OP_JAL)
         m = NEED_PC | NEED_OFF;
      else if (op == rsws_pkg::OP_JALR)
         m = NEED_PC | NEED_A | NEED_B;
      else if (op == rsws_pkg::OP_AUIPC)
         m = NEED_PC | NEED_B;
      else if (op == rsws_pkg::OP_LUI)
         m = NEED_B;
      return m;
   endfunction

   // While an operand waits, its producer tag sits in the low bits of the
   // operand word, so the word itself serves as the wait tag.
   task automatic wake_waiters(input logic [rsws_pkg::TAG_W-1:0] tag,
                               input logic [rsws_pkg::DATA_W-1:0] value);
      slot_type s;
      for (int i = 0; i < STATION_SIZE; i++) begin
         if (occupied[i]) begin
            s = slots[i];
            if (s.flags[rsws_pkg::FL_W1] && s.first[rsws_pkg::TAG_W-1:0] == tag) begin
               s.flags[rsws_pkg::FL_W1] = 1'b0;
               s.flags[rsws_pkg::FL_V1] = 1'b1;
               s.first                  = value;
            end
            if (s.flags[rsws_pkg::FL_W2] && s.second[rsws_pkg::TAG_W-1:0] == tag) begin
               s.flags[rsws_pkg::FL_W2] = 1'b0;
               s.flags[rsws_pkg::FL_V2] = 1'b1;
               s.second                 = value;
            end
            slots[i] = s;
         end
      end
   endtask

   task automatic advance_station(input rsws_pkg::req_type c, output rsws_pkg::rsp_type r);
      int         pick;
      int         hole;
      logic [3:0] need;
      logic [3:0] sent;
      r    = '0;
      pick = -1;
      hole = -1;
      sent = '0;
      for (int i = 0; i < STATION_SIZE; i++)
         if (!occupied[i]) r.has_free_slot = 1'b1;
      // Select works on the state held before this transfer.
      if (!flush_prev) begin
         for (int i = 0; i < STATION_SIZE; i++) begin
            if (pick < 0 && occupied[i]) begin
               need = operands_needed(slots[i].op);
               if (need != '0 && (slots[i].flags[3:0] & need) == need) begin
                  pick = i;
                  sent = need;
               end
            end
         end
      end
      if (pick >= 0) begin
         r.dispatch_valid = 1'b1;
         r.out_op         = slots[pick].op;
         r.out_tag        = slots[pick].rob_id;
         r.out_pc         = sent[rsws_pkg::FL_PC]  ? slots[pick].pc     : '0;
         r.out_offset     = sent[rsws_pkg::FL_OFF] ? slots[pick].offset : '0;
         r.out_src1       = sent[rsws_pkg::FL_V1]  ? slots[pick].first  : '0;
         r.out_src2       = sent[rsws_pkg::FL_V2]  ? slots[pick].second : '0;
         occupied[pick]   = 1'b0;
      end
      if (c.control[rsws_pkg::CTL_FLUSH]) begin
         for (int i = 0; i < STATION_SIZE; i++) occupied[i] = 1'b0;
      end else begin
         if (c.control[rsws_pkg::CTL_ISSUE]) begin
            for (int i = 0; i < STATION_SIZE; i++)
               if (hole < 0 && !occupied[i]) hole = i;
            if (hole < 0) begin
               r.issue_dropped = 1'b1;
            end else begin
               occupied[hole] = 1'b1;
               slots[hole]    = {c.issue_op, c.issue_tag, c.issue_pc, c.issue_offset,
                                 c.issue_flags, c.issue_src1, c.issue_src2};
            end
         end
         // The load store queue bus is applied after the ALU bus.
         if (c.control[rsws_pkg::CTL_ALU])
            wake_waiters(c.alu_bcast_tag, c.alu_bcast_value);
         if (c.control[rsws_pkg::CTL_LSQ])
            wake_waiters(c.lsq_bcast_tag, c.lsq_bcast_value);
      end
      flush_prev = c.control[rsws_pkg::CTL_FLUSH];
   endtask

   function automatic string show(rsws_pkg::rsp_type r);
      return $sformatf("free=%b disp=%b op=%0d tag=%0d pc=%h off=%h s1=%h s2=%h drop=%b",
                       r.has_free_slot, r.dispatch_valid, r.out_op, r.out_tag, r.out_pc,
                       r.out_offset, r.out_src1, r.out_src2, r.issue_dropped);
   endfunction

   always @(posedge clock) begin : watch
      rsws_pkg::rsp_type want;
      logic              bad;
      if (reset) begin
         for (int i = 0; i < STATION_SIZE; i++) occupied[i] = 1'b0;
         flush_prev = 1'b0;
         dispatch_q.delete();
         mismatches = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (dispatch_q.size() == 0) begin
               if (mismatches < REPORT_LIMIT)
                  $display("%0t: response transfer with none predicted: %s",
                           $time, show(rsp_payload));
               mismatches++;
            end else begin
               want = dispatch_q.pop_front();
               bad  = (rsp_payload.has_free_slot  !== want.has_free_slot)  ||
                      (rsp_payload.dispatch_valid !== want.dispatch_valid) ||
                      (rsp_payload.out_op         !== want.out_op)         ||
                      (rsp_payload.out_tag        !== want.out_tag)        ||
                      (rsp_payload.out_pc         !== want.out_pc)         ||
                      (rsp_payload.out_offset     !== want.out_offset)     ||
                      (rsp_payload.out_src1       !== want.out_src1)       ||
                      (rsp_payload.out_src2       !== want.out_src2)       ||
                      (rsp_payload.issue_dropped  !== want.issue_dropped);
               if (bad) begin
                  if (mismatches < REPORT_LIMIT) begin
                     $display("%0t: response mismatch", $time);
                     $display("   expected %s", show(want));
                     $display("   actual   %s", show(rsp_payload));
                  end
                  mismatches++;
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_station(req_payload, want);
            dispatch_q.push_back(want);
         end
      end
      outstanding = dispatch_q.size();
   end

endmodule

[tb/tb_reservation_station_wakeup_select.sv]
// Top of the reservation station testbench: clock, reset, request and
// response traffic, and the verdict. Depends on rsws_pkg, the station RTL
// and rsws_dispatch_checker.
module tb_reservation_station_wakeup_select;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [rsws_pkg::OP_W-1:0]   op_type;
   typedef logic [rsws_pkg::TAG_W-1:0]  tag_type;
   typedef logic [rsws_pkg::FLAG_W-1:0] flags_type;

   localparam int STATION_SIZE = 16;
   localparam int ITEM_TARGET  = 1750;
   localparam int CYCLE_LIMIT  = 100000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AFTER   = 600;
   localparam int DRAIN_CYCLES = 8;

   localparam op_type OP_FIRST_ALU    = '0;
   localparam op_type OP_FIRST_BRANCH = op_type'(rsws_pkg::OP_LAST_ALU + 1);
   localparam op_type OP_FIRST_UNUSED = op_type'(rsws_pkg::OP_LUI + 1);
   localparam op_type OP_LAST_UNUSED  = '1;

   localparam logic [3:0] DO_FLUSH = 4'(1 << rsws_pkg::CTL_FLUSH);
   localparam logic [3:0] DO_ISSUE = 4'(1 << rsws_pkg::CTL_ISSUE);
   localparam logic [3:0] DO_ALU   = 4'(1 << rsws_pkg::CTL_ALU);
   localparam logic [3:0] DO_LSQ   = 4'(1 << rsws_pkg::CTL_LSQ);

   localparam flags_type F_PC  = flags_type'(1 << rsws_pkg::FL_PC);
   localparam flags_type F_OFF = flags_type'(1 << rsws_pkg::FL_OFF);
   localparam flags_type F_V1  = flags_type'(1 << rsws_pkg::FL_V1);
   localparam flags_type F_V2  = flags_type'(1 << rsws_pkg::FL_V2);
   localparam flags_type F_W1  = flags_type'(1 << rsws_pkg::FL_W1);
   localparam flags_type F_W2  = flags_type'(1 << rsws_pkg::FL_W2);

   typedef enum logic [1:0] {BURST_MIX, BURST_FILL, BURST_DRAIN} burst_type;
   typedef enum logic [1:0] {ALWAYS_READY, COIN_FLIP, ONE_IN_FOUR} stall_type;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   rsws_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsws_pkg::rsp_type rsp_payload;
   int                mismatches;
   int                outstanding;
   int                items_sent = 0;
   int                cycle_count = 0;
   logic              long_hold_done = 1'b0;

   always #5 clock = ~clock;

   reservation_station_wakeup_select #(
      .STATION_ENTRIES(STATION_SIZE)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload)
   );

   rsws_dispatch_checker #(
      .STATION_SIZE(STATION_SIZE)
   ) dispatch_check (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_payload(req_payload),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_payload(rsp_payload),
      .mismatches (mismatches),
      .outstanding(outstanding)
   );

   initial begin
      repeat (7) @(negedge clock);
      reset = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("reservation_station_wakeup_select verification failed");
         $finish;
      end
   end

   // Producer tags crowd into a small window so broadcasts often hit.
   function automatic tag_type pick_tag();
      tag_type t;
      t = tag_type'($urandom);
      if ($urandom_range(0, 9) < 8) t = tag_type'($urandom_range(0, 7));
      return t;
   endfunction

   function automatic rsws_pkg::req_type issue_cycle(op_type op, flags_type flags);
      rsws_pkg::req_type c;
      c.control         = DO_ISSUE;
      c.issue_op        = op;
      c.issue_tag       = tag_type'($urandom);
      c.issue_pc        = $urandom;
      c.issue_offset    = $urandom;
      c.issue_flags     = flags;
      c.issue_src1      = $urandom;
      c.issue_src2      = $urandom;
      c.alu_bcast_tag   = pick_tag();
      c.alu_bcast_value = $urandom;
      c.lsq_bcast_tag   = pick_tag();
      c.lsq_bcast_value = $urandom;
      return c;
   endfunction

   function automatic rsws_pkg::req_type make_cycle(burst_type kind);
      rsws_pkg::req_type c;
      logic [3:0]        ctl;
      op_type            op;
      flags_type         fl;
      tag_type           t1;
      tag_type           t2;
      int                wait_odds;
      op = op_type'($urandom_range(0, rsws_pkg::OP_LUI));
      if ($urandom_range(0, 19) == 0)
         op = op_type'($urandom_range(OP_FIRST_UNUSED, OP_LAST_UNUSED));
      wait_odds = (kind == BURST_FILL) ? 2 : 4;
      // Mostly clean operand states: each operand either valid or waiting.
      if ($urandom_range(0, 9) < 7) begin
         fl = '0;
         if ($urandom_range(0, 9) != 0) fl |= F_PC;
         if ($urandom_range(0, 9) != 0) fl |= F_OFF;
         fl |= ($urandom_range(1, wait_odds) == 1) ? F_W1 : F_V1;
         fl |= ($urandom_range(1, wait_odds) == 1) ? F_W2 : F_V2;
      end else begin
         fl = flags_type'($urandom);
      end
      t1 = pick_tag();
      t2 = pick_tag();
      c  = issue_cycle(op, fl);
      if ((fl & F_W1) != '0) c.issue_src1[rsws_pkg::TAG_W-1:0] = t1;
      if ((fl & F_W2) != '0) c.issue_src2[rsws_pkg::TAG_W-1:0] = t2;
      ctl = '0;
      case (kind)
         BURST_FILL: begin
            ctl = DO_ISSUE;
            if ($urandom_range(0, 9) == 0) ctl |= DO_ALU;
         end
         BURST_DRAIN: begin
            ctl = DO_ALU;
            if ($urandom_range(0, 1) != 0) ctl |= DO_LSQ;
            if ($urandom_range(0, 4) == 0) ctl |= DO_ISSUE;
            if ($urandom_range(0, 99) == 0) ctl |= DO_FLUSH;
         end
         default: begin
            if ($urandom_range(0, 49) == 0) ctl |= DO_FLUSH;
            if ($urandom_range(0, 9) < 7) ctl |= DO_ISSUE;
            if ($urandom_range(0, 1) != 0) ctl |= DO_ALU;
            if ($urandom_range(0, 9) < 4) ctl |= DO_LSQ;
         end
      endcase
      c.control = ctl;
      return c;
   endfunction

   // Valid stays high from here until the transfer; the next item may
   // replace the payload at the following falling edge.
   task automatic send_cycle(input rsws_pkg::req_type item);
      req_payload = item;
      req_valid   = 1'b1;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
      items_sent++;
   endtask

   initial begin : stimulus
      rsws_pkg::req_type d;
      op_type            op_k;
      int                random_goal;
      int                roll;
      burst_type         kind;
      wait (!reset);
      @(negedge clock);

      // Fill every slot with ops that never become ready.
      for (int k = 0; k < STATION_SIZE; k++) begin
         op_k = op_type'(OP_FIRST_UNUSED + (k % 3));
         d    = issue_cycle(op_k, flags_type'($urandom));
         if (k == 0) begin
            d.issue_pc     = '1;
            d.issue_offset = '1;
            d.issue_src1   = '1;
            d.issue_src2   = '1;
         end else if (k == 1) begin
            d.issue_pc     = '0;
            d.issue_offset = '0;
            d.issue_src1   = '0;
            d.issue_src2   = '0;
         end
         send_cycle(d);
      end
      // Issue into a full station is dropped.
      d         = issue_cycle(rsws_pkg::OP_LAST_ALU, F_V1 | F_V2);
      d.control = DO_ISSUE | DO_ALU | DO_LSQ;
      send_cycle(d);
      // A flush empties the station and ignores issue and broadcasts.
      d         = issue_cycle(rsws_pkg::OP_JAL, F_PC | F_OFF);
      d.control = DO_FLUSH | DO_ISSUE | DO_ALU | DO_LSQ;
      send_cycle(d);
      // One of each class with its operands in place.
      d            = issue_cycle(rsws_pkg::OP_LAST_ALU, F_V1 | F_V2);
      d.issue_src1 = '1;
      d.issue_src2 = '0;
      send_cycle(d);
      send_cycle(issue_cycle(OP_FIRST_BRANCH, F_PC | F_OFF | F_V1 | F_V2));
      send_cycle(issue_cycle(rsws_pkg::OP_JAL, F_PC | F_OFF));
      send_cycle(issue_cycle(rsws_pkg::OP_JALR, F_PC | F_V1 | F_V2));
      send_cycle(issue_cycle(rsws_pkg::OP_AUIPC, F_PC | F_V2));
      send_cycle(issue_cycle(rsws_pkg::OP_LUI, F_V2));
      // Woken by the ALU bus in the cycle it is issued.
      d                                 = issue_cycle(OP_FIRST_ALU, F_W1 | F_V2);
      d.issue_src1[rsws_pkg::TAG_W-1:0] = d.alu_bcast_tag;
      d.control                         = DO_ISSUE | DO_ALU;
      send_cycle(d);
      // Valid and waiting at once: the broadcast still replaces the value.
      d = issue_cycle(rsws_pkg::OP_LAST_BRANCH, F_PC | F_OFF | F_V1 | F_V2 | F_W2);
      d.issue_src2[rsws_pkg::TAG_W-1:0] = d.lsq_bcast_tag;
      d.control                         = DO_ISSUE | DO_LSQ;
      send_cycle(d);

      random_goal = items_sent + ITEM_TARGET;
      while (items_sent < random_goal) begin
         roll = $urandom_range(0, 9);
         kind = (roll < 6) ? BURST_MIX : (roll < 8) ? BURST_FILL : BURST_DRAIN;
         repeat ($urandom_range(1, 48)) send_cycle(make_cycle(kind));
         if ($urandom_range(0, 3) != 0) begin
            req_valid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge clock);
         end
      end
      req_valid = 1'b0;

      wait (outstanding == 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("reservation_station_wakeup_select verification clean");
      end else begin
         $display("reservation_station_wakeup_select verification failed");
      end
      $finish;
   end

   initial begin : response_side
      int        span;
      int        roll;
      stall_type style;
      wait (!reset);
      forever begin
         // One long hold-off so the station and its input back up.
         if (!long_hold_done && items_sent >= HOLD_AFTER) begin
            long_hold_done = 1'b1;
            rsp_ready      = 1'b0;
            repeat (LONG_HOLD) @(negedge clock);
         end
         roll  = $urandom_range(0, 2);
         style = (roll == 0) ? ALWAYS_READY : (roll == 1) ? COIN_FLIP : ONE_IN_FOUR;
         span  = $urandom_range(8, 64);
         for (int k = 0; k < span; k++) begin
            case (style)
               ALWAYS_READY: rsp_ready = 1'b1;
               COIN_FLIP:    rsp_ready = 1'($urandom_range(0, 1));
               default:      rsp_ready = (k % 4) != 3;
            endcase
            @(negedge clock);
         end
      end
   end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/rsws_pkg.sv
rtl/core/rsws_cell.sv
rtl/core/reservation_station_wakeup_select.sv
tb/rsws_dispatch_checker.sv
tb/tb_reservation_station_wakeup_select.sv
